// File: sv/csh_pkg.sv
package csh_pkg;

  typedef enum logic [2:0] {
    OP_CALL    = 3'd0,
    OP_PICK_UP = 3'd1,
    OP_HANG_UP = 3'd2,
    OP_RECEIVE = 3'd3,
    OP_TICK    = 3'd4,
    OP_POLL    = 3'd5
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE          = 6'b000001,
    ST_CALLING       = 6'b000010,
    ST_CALLER_TALK   = 6'b000100,
    ST_RINGING       = 6'b001000,
    ST_ANSWERING     = 6'b010000,
    ST_CALLEE_TALK   = 6'b100000
  } hs_state_t;

  localparam logic [2:0] CODE_IDLE        = 3'd0;
  localparam logic [2:0] CODE_CALLING     = 3'd1;
  localparam logic [2:0] CODE_CALLER_TALK = 3'd2;
  localparam logic [2:0] CODE_RINGING     = 3'd3;
  localparam logic [2:0] CODE_ANSWERING   = 3'd4;
  localparam logic [2:0] CODE_CALLEE_TALK = 3'd5;

  localparam logic [31:0] PEER_CALLING     = 32'd1;
  localparam logic [31:0] PEER_CALLER_TALK = 32'd2;
  localparam logic [31:0] PEER_ANSWERING   = 32'd4;
  localparam logic [31:0] PEER_CALLEE_TALK = 32'd5;
  localparam logic [31:0] PEER_HANG_UP     = 32'd6;

  localparam logic [63:0] HANG_UP_WORD = 64'd6;

  localparam logic [15:0] RING_MIN   = 16'd5000;
  localparam logic [14:0] ACK_MIN    = 15'd100;
  localparam logic [16:0] SINCE_MAX  = 17'h1FFFF;

  localparam logic [15:0] RING_RESET = 16'd30000;
  localparam logic [14:0] ACK_RESET  = 15'd200;
  localparam logic [15:0] HB_RESET   = 16'd1000;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RINGING   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_PERIOD    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_ANSWER = 8'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic        is_response;
    logic [63:0] peer_word;
    logic [15:0] random_id;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  call_state;
    logic        send_is_response;
    logic [63:0] send_word;
  } out_word_t;

  function automatic logic [2:0] state_code(input hs_state_t st);
    logic [2:0] code;
    unique case (st)
      ST_IDLE:        code = CODE_IDLE;
      ST_CALLING:     code = CODE_CALLING;
      ST_CALLER_TALK: code = CODE_CALLER_TALK;
      ST_RINGING:     code = CODE_RINGING;
      ST_ANSWERING:   code = CODE_ANSWERING;
      ST_CALLEE_TALK: code = CODE_CALLEE_TALK;
      default:        code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: sv/call_setup_handshake_unit.sv
// Each taken word's result is registered: in the output register, or in the skid entry if busy.
// Throughput: one word per cycle; a two-entry output buffer keeps the input open for one
// more word while a result waits, so the input stalls only when both entries are full.
// Reset (synchronous, rst_n low): idle state, cleared ids, counters and pending word,
// configuration registers at their defaults, output buffer empty.
module call_setup_handshake_unit
  import csh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] max_ringing_r, max_ringing_nxt;
  logic [14:0] ack_period_r, ack_period_nxt;
  logic [15:0] heartbeat_r, heartbeat_nxt;
  logic        always_answer_r, always_answer_nxt;

  hs_state_t   state_r, state_nxt;
  logic [15:0] own_id_r, own_id_nxt;
  logic [15:0] partner_id_r, partner_id_nxt;
  logic        answer_allowed_r, answer_allowed_nxt;
  logic        send_pending_r, send_pending_nxt;
  logic [63:0] pending_word_r, pending_word_nxt;
  logic [16:0] since_r, since_nxt;
  logic [15:0] send_wait_r, send_wait_nxt;

  logic        out_valid_r, skid_valid_r;
  out_word_t   out_word_r, skid_word_r;
  out_word_t   result;

  logic        in_accept, out_fire;
  logic [15:0] peer_id, mine_id;
  logic [31:0] peer_state;
  logic [15:0] twice_ack, hb_limit, limit;
  logic [1:0]  opt;
  logic [15:0] cfg_v16;
  logic [14:0] cfg_v15;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign out_fire  = out_valid_r && !out_stall;

  assign peer_id    = in_data.peer_word[63:48];
  assign mine_id    = in_data.peer_word[47:32];
  assign peer_state = in_data.peer_word[31:0];
  assign twice_ack  = {ack_period_r, 1'b0};
  assign hb_limit   = (heartbeat_r < twice_ack) ? twice_ack : heartbeat_r;
  assign limit      = (state_r == ST_CALLING || state_r == ST_RINGING) ? max_ringing_r : hb_limit;
  assign cfg_v16    = cfg_wdata;
  assign cfg_v15    = cfg_wdata[14:0];

  always_comb begin
    state_nxt          = state_r;
    own_id_nxt         = own_id_r;
    partner_id_nxt     = partner_id_r;
    answer_allowed_nxt = answer_allowed_r;
    send_pending_nxt   = send_pending_r;
    pending_word_nxt   = pending_word_r;
    since_nxt          = since_r;
    send_wait_nxt      = send_wait_r;
    max_ringing_nxt    = max_ringing_r;
    ack_period_nxt     = ack_period_r;
    heartbeat_nxt      = heartbeat_r;
    always_answer_nxt  = always_answer_r;
    opt                = 2'd0;
    result             = '0;

    if (in_accept) begin
      case (in_data.operation)
        OP_CALL: begin
          if (state_r == ST_IDLE) begin
            state_nxt        = ST_CALLING;
            own_id_nxt       = in_data.random_id;
            since_nxt        = '0;
            send_wait_nxt    = '0;
            pending_word_nxt = {in_data.random_id, 16'd0, 29'd0, CODE_CALLING};
            send_pending_nxt = 1'b1;
            result.accepted  = 1'b1;
          end
        end
        OP_PICK_UP: begin
          if (!always_answer_r && state_r == ST_RINGING) begin
            answer_allowed_nxt = 1'b1;
            result.accepted    = 1'b1;
          end
        end
        OP_HANG_UP: begin
          if (state_r != ST_IDLE) begin
            pending_word_nxt = HANG_UP_WORD;
            send_wait_nxt    = '0;
            send_pending_nxt = 1'b1;
            state_nxt        = ST_IDLE;
            result.accepted  = 1'b1;
          end
        end
        OP_RECEIVE: begin
          if (peer_state == PEER_HANG_UP) begin
            state_nxt        = ST_IDLE;
            send_pending_nxt = 1'b0;
            if (!always_answer_r) begin
              answer_allowed_nxt = 1'b0;
            end
          end else begin
            unique case (state_r)
              ST_IDLE: begin
                if (!in_data.is_response && peer_state == PEER_CALLING) begin
                  own_id_nxt = in_data.random_id;
                  state_nxt  = ST_RINGING;
                  since_nxt  = '0;
                end
              end
              ST_CALLING: begin
                if (in_data.is_response && mine_id == own_id_r &&
                    peer_state == PEER_ANSWERING) begin
                  state_nxt = ST_CALLER_TALK;
                  opt       = 2'd1;
                end
              end
              ST_CALLER_TALK: begin
                if (in_data.is_response && mine_id == own_id_r &&
                    peer_state == PEER_CALLEE_TALK) begin
                  opt = 2'd2;
                end
              end
              ST_RINGING: begin
                if (!in_data.is_response && answer_allowed_r &&
                    peer_state == PEER_CALLING) begin
                  state_nxt = ST_ANSWERING;
                  opt       = 2'd1;
                end
              end
              ST_ANSWERING, ST_CALLEE_TALK: begin
                if (!in_data.is_response && mine_id == own_id_r &&
                    peer_state == PEER_CALLER_TALK) begin
                  state_nxt = ST_CALLEE_TALK;
                  opt       = 2'd2;
                end
              end
              default: begin
              end
            endcase
            if (opt != 2'd0) begin
              since_nxt        = '0;
              send_wait_nxt    = (opt == 2'd2) ? {1'b0, ack_period_r} : 16'd0;
              partner_id_nxt   = peer_id;
              pending_word_nxt = {own_id_r, peer_id, 29'd0, state_code(state_nxt)};
              send_pending_nxt = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (send_wait_r != 16'd0) begin
            send_wait_nxt = send_wait_r - 16'd1;
          end
          if (since_r != SINCE_MAX) begin
            since_nxt = since_r + 17'd1;
          end
          if (state_r != ST_IDLE && since_nxt > {1'b0, limit}) begin
            state_nxt        = ST_IDLE;
            pending_word_nxt = HANG_UP_WORD;
            send_wait_nxt    = '0;
            send_pending_nxt = 1'b1;
            if (!always_answer_r) begin
              answer_allowed_nxt = 1'b0;
            end
          end
        end
        OP_POLL: begin
          if (send_pending_r && send_wait_r == 16'd0) begin
            result.send_is_response = (state_r != ST_CALLING && state_r != ST_CALLER_TALK);
            result.send_word        = pending_word_r;
            result.accepted         = 1'b1;
            if (state_r == ST_CALLING) begin
              send_wait_nxt = {1'b0, ack_period_r};
            end else begin
              send_pending_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
      result.call_state = state_code(state_nxt);
    end

    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_RINGING:   max_ringing_nxt = (cfg_v16 < RING_MIN) ? RING_MIN : cfg_v16;
        REG_ACK_PERIOD:    ack_period_nxt  = (cfg_v15 < ACK_MIN) ? ACK_MIN : cfg_v15;
        REG_HEARTBEAT:     heartbeat_nxt   = cfg_v16;
        REG_ALWAYS_ANSWER: begin
          always_answer_nxt  = cfg_wdata[0];
          answer_allowed_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ringing_r    <= RING_RESET;
      ack_period_r     <= ACK_RESET;
      heartbeat_r      <= HB_RESET;
      always_answer_r  <= 1'b0;
      state_r          <= ST_IDLE;
      own_id_r         <= '0;
      partner_id_r     <= '0;
      answer_allowed_r <= 1'b0;
      send_pending_r   <= 1'b0;
      pending_word_r   <= '0;
      since_r          <= '0;
      send_wait_r      <= '0;
    end else begin
      max_ringing_r    <= max_ringing_nxt;
      ack_period_r     <= ack_period_nxt;
      heartbeat_r      <= heartbeat_nxt;
      always_answer_r  <= always_answer_nxt;
      state_r          <= state_nxt;
      own_id_r         <= own_id_nxt;
      partner_id_r     <= partner_id_nxt;
      answer_allowed_r <= answer_allowed_nxt;
      send_pending_r   <= send_pending_nxt;
      pending_word_r   <= pending_word_nxt;
      since_r          <= since_nxt;
      send_wait_r      <= send_wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_word_r   <= skid_word_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_fire) begin
        skid_word_r  <= result;
        skid_valid_r <= 1'b1;
      end else begin
        out_word_r  <= result;
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import csh_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  call_setup_handshake_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow copy of the registers and the handshake state.
  logic [15:0] ring_limit;
  logic [14:0] ack_ms;
  logic [15:0] hb_ms;
  logic        auto_answer;
  logic [2:0]  hs;
  logic [15:0] my_id;
  logic [15:0] peer_id;
  logic        may_answer;
  logic        word_waiting;
  logic [63:0] waiting_word;
  logic [16:0] since_rx;
  logic [15:0] send_hold;

  in_word_t  call_events[$];
  out_word_t predicted_replies[$];

  int words_in = 0;
  int words_out = 0;
  int mismatches = 0;
  int settings_used = 1;
  int scripted = 0;
  int in_gap = 0;
  bit in_quiet = 1'b0;
  int stall_left = 0;
  int hold_left = 0;
  bit out_quiet = 1'b0;
  int hold_asked = 0;
  int hold_seen = 0;
  int quiet_cycles = 0;

  task automatic reset_shadow();
    ring_limit = RING_RESET;
    ack_ms = ACK_RESET;
    hb_ms = HB_RESET;
    auto_answer = 1'b0;
    hs = CODE_IDLE;
    my_id = '0;
    peer_id = '0;
    may_answer = 1'b0;
    word_waiting = 1'b0;
    waiting_word = '0;
    since_rx = '0;
    send_hold = '0;
  endtask

  function automatic logic [16:0] hb_limit();
    logic [16:0] twice;
    twice = {1'b0, ack_ms, 1'b0};
    return ({1'b0, hb_ms} < twice) ? twice : {1'b0, hb_ms};
  endfunction

  function automatic out_word_t advance_handshake(input in_word_t ev);
    out_word_t res;
    logic [15:0] mine;
    logic [15:0] far;
    logic [31:0] pst;
    logic [16:0] limit;
    int reply;
    res = '0;
    reply = 0;
    case (ev.operation)
      OP_CALL: begin
        if (hs == CODE_IDLE) begin
          hs = CODE_CALLING;
          my_id = ev.random_id;
          since_rx = '0;
          send_hold = '0;
          waiting_word = {my_id, 16'h0000, 29'd0, CODE_CALLING};
          word_waiting = 1'b1;
          res.accepted = 1'b1;
        end
      end
      OP_PICK_UP: begin
        if (!auto_answer && hs == CODE_RINGING) begin
          may_answer = 1'b1;
          res.accepted = 1'b1;
        end
      end
      OP_HANG_UP: begin
        if (hs != CODE_IDLE) begin
          waiting_word = HANG_UP_WORD;
          send_hold = '0;
          word_waiting = 1'b1;
          hs = CODE_IDLE;
          res.accepted = 1'b1;
        end
      end
      OP_RECEIVE: begin
        far = ev.peer_word[63:48];
        mine = ev.peer_word[47:32];
        pst = ev.peer_word[31:0];
        if (pst == PEER_HANG_UP) begin
          hs = CODE_IDLE;
          if (!auto_answer) may_answer = 1'b0;
          word_waiting = 1'b0;
        end else begin
          case (hs)
            CODE_IDLE: begin
              if (!ev.is_response && pst == PEER_CALLING) begin
                my_id = ev.random_id;
                hs = CODE_RINGING;
                since_rx = '0;
              end
            end
            CODE_CALLING: begin
              if (ev.is_response && mine == my_id && pst == PEER_ANSWERING) begin
                hs = CODE_CALLER_TALK;
                reply = 1;
              end
            end
            CODE_CALLER_TALK: begin
              if (ev.is_response && mine == my_id && pst == PEER_CALLEE_TALK) reply = 2;
            end
            CODE_RINGING: begin
              if (!ev.is_response && may_answer && pst == PEER_CALLING) begin
                hs = CODE_ANSWERING;
                reply = 1;
              end
            end
            CODE_ANSWERING, CODE_CALLEE_TALK: begin
              if (!ev.is_response && mine == my_id && pst == PEER_CALLER_TALK) begin
                hs = CODE_CALLEE_TALK;
                reply = 2;
              end
            end
            default: begin
            end
          endcase
          if (reply != 0) begin
            since_rx = '0;
            send_hold = (reply == 2) ? {1'b0, ack_ms} : 16'd0;
            peer_id = far;
            waiting_word = {my_id, peer_id, 29'd0, hs};
            word_waiting = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (send_hold != 16'd0) send_hold = send_hold - 16'd1;
        if (since_rx != SINCE_MAX) since_rx = since_rx + 17'd1;
        if (hs != CODE_IDLE) begin
          limit = (hs == CODE_CALLING || hs == CODE_RINGING) ? {1'b0, ring_limit} : hb_limit();
          if (since_rx > limit) begin
            hs = CODE_IDLE;
            if (!auto_answer) may_answer = 1'b0;
            waiting_word = HANG_UP_WORD;
            send_hold = '0;
            word_waiting = 1'b1;
          end
        end
      end
      OP_POLL: begin
        if (word_waiting && send_hold == 16'd0) begin
          res.send_is_response = (hs != CODE_CALLING && hs != CODE_CALLER_TALK);
          res.send_word = waiting_word;
          if (hs == CODE_CALLING) send_hold = {1'b0, ack_ms};
          else word_waiting = 1'b0;
          res.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.call_state = hs;
    return res;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic rand_bit();
    return ($urandom & 1) != 0;
  endfunction

  function automatic logic [15:0] rand_id();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic push_event(input logic [2:0] op, input logic resp, input logic [63:0] word,
                            input logic [15:0] rid);
    in_word_t ev;
    ev.operation = op;
    ev.is_response = resp;
    ev.peer_word = word;
    ev.random_id = rid;
    call_events.push_back(ev);
    scripted++;
  endtask

  task automatic poll();
    push_event(OP_POLL, rand_bit(), rand_word(), rand_id());
  endtask

  task automatic add_ticks(input int n);
    in_word_t ev;
    repeat (n) begin
      ev.operation = OP_TICK;
      ev.is_response = rand_bit();
      ev.peer_word = rand_word();
      ev.random_id = rand_id();
      call_events.push_back(ev);
    end
    scripted += n;
  endtask

  task automatic push_noise();
    logic [31:0] r;
    r = $urandom;
    push_event(r[2:0], r[3], rand_word(), rand_id());
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) push_noise();
  endtask

  function automatic int ack_wait();
    int r;
    r = $urandom_range(0, 3);
    if (ack_ms > 15'd300) return r;
    if (r == 0) return int'(ack_ms) - 1;
    if (r == 3) return $urandom_range(0, 3);
    return int'(ack_ms);
  endfunction

  task automatic close_session();
    logic [16:0] lim;
    int r;
    lim = hb_limit();
    r = $urandom_range(0, 7);
    if (r < 4) begin
      push_event(OP_HANG_UP, rand_bit(), rand_word(), rand_id());
      poll();
    end else if (r < 6) begin
      push_event(OP_RECEIVE, rand_bit(), {$urandom, PEER_HANG_UP}, rand_id());
      poll();
    end else begin
      if (lim <= 17'd400) begin
        add_ticks(int'(lim));
        poll();
        add_ticks(1);
        poll();
      end
      push_event(OP_HANG_UP, rand_bit(), rand_word(), rand_id());
      poll();
    end
  endtask

  task automatic caller_session();
    logic [15:0] rid;
    logic [15:0] mine;
    int n;
    rid = rand_id();
    mine = ($urandom_range(0, 6) == 0) ? (rid ^ (16'h0001 << $urandom_range(0, 15))) : rid;
    push_event(OP_CALL, rand_bit(), rand_word(), rid);
    poll();
    if ($urandom_range(0, 1) == 1) begin
      add_ticks(ack_wait());
      poll();
    end
    maybe_noise();
    push_event(OP_RECEIVE, $urandom_range(0, 9) != 0, {rand_id(), mine, PEER_ANSWERING},
               rand_id());
    poll();
    n = $urandom_range(0, 2);
    repeat (n) begin
      push_event(OP_RECEIVE, $urandom_range(0, 9) != 0, {rand_id(), mine, PEER_CALLEE_TALK},
                 rand_id());
      add_ticks(ack_wait());
      poll();
      maybe_noise();
    end
    close_session();
  endtask

  task automatic callee_session();
    logic [15:0] rid;
    logic [15:0] far;
    logic [15:0] mine;
    int n;
    rid = rand_id();
    far = rand_id();
    mine = ($urandom_range(0, 6) == 0) ? (rid ^ (16'h0001 << $urandom_range(0, 15))) : rid;
    push_event(OP_RECEIVE, $urandom_range(0, 9) == 0, {far, rand_id(), PEER_CALLING}, rid);
    if ($urandom_range(0, 5) != 0) push_event(OP_PICK_UP, rand_bit(), rand_word(), rand_id());
    maybe_noise();
    push_event(OP_RECEIVE, $urandom_range(0, 9) == 0, {far, rand_id(), PEER_CALLING},
               rand_id());
    poll();
    n = $urandom_range(0, 2);
    repeat (n) begin
      push_event(OP_RECEIVE, $urandom_range(0, 9) == 0, {rand_id(), mine, PEER_CALLER_TALK},
                 rand_id());
      add_ticks(ack_wait());
      poll();
      maybe_noise();
    end
    close_session();
  endtask

  task automatic random_phase(input int target);
    scripted = 0;
    while (scripted < target) begin
      if ($urandom_range(0, 1) == 1) caller_session();
      else callee_session();
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) push_noise();
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MAX_RINGING: ring_limit = (val < RING_MIN) ? RING_MIN : val;
      REG_ACK_PERIOD: ack_ms = (val[14:0] < ACK_MIN) ? ACK_MIN : val[14:0];
      REG_HEARTBEAT: hb_ms = val;
      REG_ALWAYS_ANSWER: begin
        auto_answer = val[0];
        may_answer = val[0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (call_events.size() != 0 || in_valid || predicted_replies.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(advance_handshake(in_data));
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (call_events.size() != 0) begin
          in_data <= call_events.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap(in_quiet);
          if ($urandom_range(0, 49) == 0) in_quiet <= !in_quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_out++;
        if (predicted_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word %h with nothing outstanding", out_data);
        end else begin
          want = predicted_replies.pop_front();
          if (out_data.accepted !== want.accepted || out_data.call_state !== want.call_state ||
              out_data.send_is_response !== want.send_is_response ||
              out_data.send_word !== want.send_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result %0d: expected acc=%b state=%0d resp=%b word=%h",
                       words_out, want.accepted, want.call_state, want.send_is_response,
                       want.send_word);
              $display("  got acc=%b state=%0d resp=%b word=%h",
                       out_data.accepted, out_data.call_state,
                       out_data.send_is_response, out_data.send_word);
            end
          end
        end
      end
      if (hold_seen != hold_asked) begin
        hold_seen <= hold_asked;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= pick_gap(out_quiet);
        if ($urandom_range(0, 49) == 0) out_quiet <= !out_quiet;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without progress", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    push_event(OP_POLL, 1'b0, '0, '0);
    push_event(OP_PICK_UP, 1'b0, '0, '0);
    push_event(OP_HANG_UP, 1'b1, '1, '1);
    push_event(OP_SPARE_LO, 1'b1, '1, '1);
    push_event(OP_SPARE_HI, 1'b0, '0, '0);
    push_event(OP_RECEIVE, 1'b1, {16'hFFFF, 16'hFFFF, PEER_CALLING}, 16'h1234);
    push_event(OP_RECEIVE, 1'b0, '1, '1);
    push_event(OP_CALL, 1'b0, '0, 16'hFFFF);
    push_event(OP_CALL, 1'b0, '0, 16'h0000);
    push_event(OP_POLL, 1'b0, '0, '0);
    push_event(OP_POLL, 1'b0, '0, '0);
    push_event(OP_RECEIVE, 1'b1, {16'h0000, 16'hFFFF, PEER_ANSWERING}, '0);
    push_event(OP_POLL, 1'b0, '0, '0);
    push_event(OP_RECEIVE, 1'b1, {16'h5A5A, 16'hFFFF, PEER_CALLEE_TALK}, '0);
    push_event(OP_POLL, 1'b0, '0, '0);
    push_event(OP_TICK, 1'b0, '0, '0);
    push_event(OP_HANG_UP, 1'b0, '0, '0);
    push_event(OP_POLL, 1'b0, '0, '0);
    push_event(OP_RECEIVE, 1'b0, {16'hFFFF, 16'h0000, PEER_CALLING}, 16'h0000);
    push_event(OP_RECEIVE, 1'b0, {16'hFFFF, 16'h0000, PEER_CALLING}, '1);
    push_event(OP_PICK_UP, 1'b0, '0, '0);
    push_event(OP_RECEIVE, 1'b0, {16'hFFFF, 16'h0000, PEER_CALLING}, '1);
    push_event(OP_POLL, 1'b0, '0, '0);
    push_event(OP_RECEIVE, 1'b0, {16'hABCD, 16'h0000, PEER_CALLER_TALK}, '1);
    push_event(OP_RECEIVE, 1'b1, {32'hFFFF_FFFF, PEER_HANG_UP}, '1);
    push_event(OP_POLL, 1'b0, '0, '0);
    wait_drained();

    // Every register at or below its minimum.
    cfg_write(REG_MAX_RINGING, 16'd4999);
    cfg_write(REG_ACK_PERIOD, 16'd99);
    cfg_write(REG_HEARTBEAT, 16'd0);
    cfg_write(REG_ALWAYS_ANSWER, 16'd0);
    settings_used++;
    @(negedge clk);
    random_phase(60);
    wait_drained();

    // Every register at its maximum, with a long stall on the result side.
    cfg_write(REG_MAX_RINGING, 16'hFFFF);
    cfg_write(REG_ACK_PERIOD, 16'hFFFF);
    cfg_write(REG_HEARTBEAT, 16'hFFFF);
    cfg_write(REG_ALWAYS_ANSWER, 16'hFFFF);
    settings_used++;
    @(negedge clk);
    random_phase(150);
    hold_asked++;
    wait_drained();

    cfg_write(REG_MAX_RINGING, RING_MIN);
    cfg_write(REG_ACK_PERIOD, 16'h8064);
    cfg_write(REG_HEARTBEAT, rand_id() % 16'd301);
    cfg_write(REG_ALWAYS_ANSWER, 16'd1);
    cfg_write(REG_ALWAYS_ANSWER, 16'd0);
    settings_used++;
    @(negedge clk);
    random_phase(60);
    wait_drained();

    cfg_write(REG_MAX_RINGING, rand_id());
    cfg_write(REG_ACK_PERIOD, {rand_bit(), 15'(rand_id() % 16'd251)});
    cfg_write(REG_HEARTBEAT, rand_id() % 16'd1001);
    cfg_write(REG_ALWAYS_ANSWER, {15'd0, rand_bit()});
    settings_used++;
    @(negedge clk);
    random_phase(60);
    wait_drained();

    repeat (20) @(posedge clk);
    if (predicted_replies.size() != 0) mismatches++;
    $display("Run covered %0d input words and %0d result words under %0d register settings.",
             words_in, words_out, settings_used);
    $display("Mismatching or unexpected results: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/csh_pkg.sv
sv/call_setup_handshake_unit.sv
bench/testbench.sv
